[rtl/core/tcfb_pkg.sv]
// Shared constants and types of the two-colour LED framebuffer scan unit.
`timescale 1ns / 1ps
`default_nettype none
package tcfb_pkg;

	localparam int PANELS     = 2;
	localparam int ROWS       = 16;
	localparam int PANEL_COLS = 32;
	localparam int COLS       = PANELS * PANEL_COLS;
	localparam int COL_W      = $clog2(COLS);
	localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROW_W      = 4;
	localparam int LINE_W     = 64;
	localparam int CNT_W      = 8;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_START = 2'd1,
		KIND_END   = 2'd2,
		KIND_DRAW  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PIX_OFF   = 2'd0,
		PIX_RED   = 2'd1,
		PIX_GREEN = 2'd2,
		PIX_BOTH  = 2'd3
	} dot_color_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_FLUSH = 1'b1
	} scan_state_t;

endpackage
`default_nettype wire

[rtl/core/tcfb_in_if.sv]
// Pixel command channel: valid/ready handshake with the command fields.
`timescale 1ns / 1ps
`default_nettype none
interface tcfb_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [7:0] pos_x;
	logic signed [7:0] pos_y;
	logic [1:0]        dot_color;

	modport source (output valid, kind, pos_x, pos_y, dot_color, input ready);
	modport sink   (input valid, kind, pos_x, pos_y, dot_color, output ready);
endinterface
`default_nettype wire

[rtl/core/tcfb_out_if.sv]
// Row scan-out channel: valid/ready handshake with one panel row.
`timescale 1ns / 1ps
`default_nettype none
interface tcfb_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  row_addr;
	logic [63:0] red_row;
	logic [63:0] green_row;
	logic        last_row;

	modport source (output valid, row_addr, red_row, green_row, last_row, input ready);
	modport sink   (input valid, row_addr, red_row, green_row, last_row, output ready);
endinterface
`default_nettype wire

[rtl/core/two_color_led_framebuffer_scan_unit.sv]
// Top level: bitplane framebuffer with nested write transactions and row scan-out.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------
//  pix_in   | in  | valid / ready   | kind, pos_x, pos_y, dot_color
//  row_out  | out | valid / ready   | row_addr, red_row, green_row, last_row
//
//  Pixel writes stream at one per cycle while pix_in is ready, the row
//  memories reading a row and writing it back in the cycle after.
//  A frame flush reads one row per cycle while row_out takes them; a stalled
//  row_out stops the row reads. pix_in is held off until the last flush row
//  has left stage 1. Reset clears the transaction counter and the per-row
//  valid flags, so the planes read as black at once without a clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module two_color_led_framebuffer_scan_unit (
	input  wire         clk,
	input  wire         arst_n,
	tcfb_in_if.sink     pix_in,
	tcfb_out_if.source  row_out
);

	// Row memories: one entry per panel row, all panels side by side.
	logic [tcfb_pkg::COLS-1:0] red_mem   [tcfb_pkg::ROWS];
	logic [tcfb_pkg::COLS-1:0] green_mem [tcfb_pkg::ROWS];
	logic [tcfb_pkg::COLS-1:0] red_rd_q;
	logic [tcfb_pkg::COLS-1:0] green_rd_q;
	logic [tcfb_pkg::ROWS-1:0] row_vld_q;

	tcfb_pkg::scan_state_t     state_q, state_d;
	logic [tcfb_pkg::CNT_W-1:0] cnt_q;
	logic [tcfb_pkg::ROW_AW-1:0] flush_row_q;

	logic                        in_fire;
	tcfb_pkg::kind_t             in_kind;
	logic                        x_ok, y_ok, on_screen, is_pixel, flush_req;
	logic                        flush_last;
	logic                        flush_issue;
	logic                        rd_en;
	logic [tcfb_pkg::ROW_AW-1:0] rd_addr;

	// Stage 1: read data returns; pixel rows are modified and written back, flush rows go on to the output.
	logic                        s1_pix_q, s1_flush_q, s1_last_q;
	logic [tcfb_pkg::ROW_AW-1:0] s1_row_q;
	logic [tcfb_pkg::COL_W-1:0]  s1_col_q;
	tcfb_pkg::dot_color_t        s1_color_s1;
	logic                        s1_vld_q, s1_fwd_q;
	logic [tcfb_pkg::COLS-1:0]   fwd_red_q, fwd_green_q;
	logic [tcfb_pkg::COLS-1:0]   base_red, base_green;
	logic [tcfb_pkg::COLS-1:0]   bit_mask;
	logic [tcfb_pkg::COLS-1:0]   wr_red, wr_green;
	logic                        wr_en;
	logic [tcfb_pkg::ROW_AW-1:0] wr_addr;
	logic                        s1_flush_adv;

	logic                        out_valid_q;
	logic [tcfb_pkg::ROW_W-1:0]  out_row_q;
	logic [tcfb_pkg::LINE_W-1:0] out_red_q, out_green_q;
	logic                        out_last_q;

	// ---------------------------------------------------------------- input
	assign in_kind   = tcfb_pkg::kind_t'(pix_in.kind);
	assign in_fire   = pix_in.valid && pix_in.ready;
	assign x_ok      = !pix_in.pos_x[7] &&
		({1'b0, pix_in.pos_x[6:0]} < 8'(tcfb_pkg::COLS));
	assign y_ok      = !pix_in.pos_y[7] &&
		({1'b0, pix_in.pos_y[6:0]} < 8'(tcfb_pkg::ROWS));
	assign on_screen = x_ok && y_ok;
	assign is_pixel  = (in_kind == tcfb_pkg::KIND_WRITE) || (in_kind == tcfb_pkg::KIND_DRAW);

	always_comb begin
		case (in_kind)
			tcfb_pkg::KIND_END:  flush_req = (cnt_q == tcfb_pkg::CNT_W'(1));
			tcfb_pkg::KIND_DRAW: flush_req = (cnt_q == '0);
			default:             flush_req = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			if (in_kind == tcfb_pkg::KIND_START && cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (in_kind == tcfb_pkg::KIND_END && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// -------------------------------------------------------- flush control
	assign flush_last   = (flush_row_q == tcfb_pkg::ROW_AW'(tcfb_pkg::ROWS - 1));
	assign s1_flush_adv = s1_flush_q && (!out_valid_q || row_out.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcfb_pkg::ST_IDLE:  if (in_fire && flush_req) state_d = tcfb_pkg::ST_FLUSH;
			tcfb_pkg::ST_FLUSH: if (flush_issue && flush_last) state_d = tcfb_pkg::ST_IDLE;
			default:            state_d = tcfb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pix_in.ready = 1'b0;
		flush_issue  = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = pix_in.pos_y[tcfb_pkg::ROW_AW-1:0];
		case (state_q)
			tcfb_pkg::ST_IDLE: begin
				pix_in.ready = !s1_flush_q;
				rd_en        = in_fire && is_pixel && on_screen;
			end
			tcfb_pkg::ST_FLUSH: begin
				// A new row is read only when stage 1 is free to take it.
				flush_issue = !s1_flush_q || s1_flush_adv;
				rd_en       = flush_issue;
				rd_addr     = flush_row_q;
			end
			default: begin
				pix_in.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcfb_pkg::ST_IDLE;
			flush_row_q <= '0;
		end else begin
			state_q <= state_d;
			if (flush_issue) begin
				flush_row_q <= flush_last ? '0 : flush_row_q + 1'b1;
			end
		end
	end

	// --------------------------------------------------------------- memory
	always_ff @(posedge clk) begin
		if (rd_en) begin
			red_rd_q   <= red_mem[rd_addr];
			green_rd_q <= green_mem[rd_addr];
		end
		if (wr_en) begin
			red_mem[wr_addr]   <= wr_red;
			green_mem[wr_addr] <= wr_green;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	// -------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_pix_q   <= 1'b0;
			s1_flush_q <= 1'b0;
		end else begin
			s1_pix_q <= rd_en && (state_q == tcfb_pkg::ST_IDLE);
			if (flush_issue) begin
				s1_flush_q <= 1'b1;
			end else if (s1_flush_adv) begin
				s1_flush_q <= 1'b0;
			end
		end
	end

	// A write-back in the cycle of a read to the same row is forwarded, since
	// the memory still returns the old contents.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_row_q    <= rd_addr;
			s1_col_q    <= pix_in.pos_x[tcfb_pkg::COL_W-1:0];
			s1_color_s1 <= tcfb_pkg::dot_color_t'(pix_in.dot_color);
			s1_last_q   <= flush_last;
			s1_vld_q    <= row_vld_q[rd_addr];
			s1_fwd_q    <= wr_en && (wr_addr == rd_addr);
			fwd_red_q   <= wr_red;
			fwd_green_q <= wr_green;
		end
	end

	assign base_red   = s1_fwd_q ? fwd_red_q   : (s1_vld_q ? red_rd_q   : '0);
	assign base_green = s1_fwd_q ? fwd_green_q : (s1_vld_q ? green_rd_q : '0);
	assign bit_mask   = tcfb_pkg::COLS'(1) << s1_col_q;
	assign wr_en      = s1_pix_q;
	assign wr_addr    = s1_row_q;

	always_comb begin
		case (s1_color_s1)
			tcfb_pkg::PIX_RED: begin
				wr_red   = base_red | bit_mask;
				wr_green = base_green;
			end
			tcfb_pkg::PIX_GREEN: begin
				wr_red   = base_red;
				wr_green = base_green | bit_mask;
			end
			tcfb_pkg::PIX_BOTH: begin
				wr_red   = base_red | bit_mask;
				wr_green = base_green | bit_mask;
			end
			default: begin
				wr_red   = base_red & ~bit_mask;
				wr_green = base_green & ~bit_mask;
			end
		endcase
	end

	// --------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_flush_adv) begin
			out_valid_q <= 1'b1;
		end else if (row_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_flush_adv) begin
			out_row_q   <= tcfb_pkg::ROW_W'(s1_row_q);
			out_red_q   <= tcfb_pkg::LINE_W'(base_red);
			out_green_q <= tcfb_pkg::LINE_W'(base_green);
			out_last_q  <= s1_last_q;
		end
	end

	assign row_out.valid     = out_valid_q;
	assign row_out.row_addr  = out_row_q;
	assign row_out.red_row   = out_red_q;
	assign row_out.green_row = out_green_q;
	assign row_out.last_row  = out_last_q;

	// ------------------------------------------------------------ assertions
	a_last_row_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(row_out.valid && row_out.last_row) |->
			(row_out.row_addr == tcfb_pkg::ROW_W'(tcfb_pkg::ROWS - 1)))
		else $error("last row flag on a row other than the final one");

	a_no_input_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcfb_pkg::ST_FLUSH || s1_flush_q) |-> !pix_in.ready)
		else $error("command taken while a frame flush is in progress");

	a_pix_flush_apart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_pix_q |-> !s1_flush_q)
		else $error("pixel write-back and flush row share stage 1");

	a_start_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_kind == tcfb_pkg::KIND_START && cnt_q != '1) |=>
			(cnt_q == $past(cnt_q) + 1'b1))
		else $error("transaction counter did not advance on start");

endmodule
`default_nettype wire

[bench/two_color_led_framebuffer_scan_unit_tb.sv]
// Self-checking testbench of the two-colour LED framebuffer scan unit.
`timescale 1ns / 1ps
`default_nettype none
module two_color_led_framebuffer_scan_unit_tb;
	import tcfb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 3 * ROWS;

	typedef struct {
		kind_t             kind;
		logic signed [7:0] x;
		logic signed [7:0] y;
		dot_color_t        color;
		bit                drain;
	} pixel_cmd_t;

	typedef struct {
		logic [ROW_W-1:0]  addr;
		logic [LINE_W-1:0] red;
		logic [LINE_W-1:0] green;
		logic              last;
	} panel_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tcfb_in_if  pix_in ();
	tcfb_out_if row_out ();

	two_color_led_framebuffer_scan_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.row_out (row_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pixel_cmd_t        cmd_queue [$];
	panel_row_t        rows_due [$];
	pixel_cmd_t        next_cmd;
	panel_row_t        got_row;
	logic [LINE_W-1:0] red_lines [ROWS] = '{default: '0};
	logic [LINE_W-1:0] green_lines [ROWS] = '{default: '0};
	logic [CNT_W-1:0]  open_cnt = '0;
	int                cmds_taken = 0;
	int                errors = 0;
	int                cycles = 0;
	logic              calm;

	// Both sides run without gaps for a stretch in the middle of the run.
	assign calm = (cmds_taken >= 120) && (cmds_taken < 260);

	function automatic void plot(logic signed [7:0] x, logic signed [7:0] y, dot_color_t c);
		if (x < 0 || x >= COLS || y < 0 || y >= ROWS)
			return;
		case (c)
			PIX_RED:    red_lines[y][x[5:0]]   = 1'b1;
			PIX_GREEN:  green_lines[y][x[5:0]] = 1'b1;
			PIX_BOTH: begin
				red_lines[y][x[5:0]]   = 1'b1;
				green_lines[y][x[5:0]] = 1'b1;
			end
			default: begin
				red_lines[y][x[5:0]]   = 1'b0;
				green_lines[y][x[5:0]] = 1'b0;
			end
		endcase
	endfunction

	function automatic void queue_frame();
		panel_row_t row;
		for (int r = 0; r < ROWS; r++) begin
			row.addr  = ROW_W'(r);
			row.red   = red_lines[r];
			row.green = green_lines[r];
			row.last  = (r == ROWS - 1);
			rows_due.push_back(row);
		end
	endfunction

	// Updates the framebuffer and the transaction depth for one accepted command, and queues the frame when it flushes.
	function automatic void apply_command(kind_t k, logic signed [7:0] x, logic signed [7:0] y,
			dot_color_t c);
		case (k)
			KIND_WRITE: plot(x, y, c);
			KIND_START: begin
				if (open_cnt != 8'hFF)
					open_cnt = open_cnt + 1'b1;
			end
			KIND_END: begin
				if (open_cnt != 0) begin
					open_cnt = open_cnt - 1'b1;
					if (open_cnt == 0)
						queue_frame();
				end
			end
			default: begin
				plot(x, y, c);
				if (open_cnt == 0)
					queue_frame();
			end
		endcase
	endfunction

	task automatic queue_cmd(kind_t k, int x, int y, int c, bit drain = 1'b0);
		pixel_cmd_t cmd;
		cmd.kind  = k;
		cmd.x     = 8'(x);
		cmd.y     = 8'(y);
		cmd.color = dot_color_t'(2'(c));
		cmd.drain = drain;
		cmd_queue.push_back(cmd);
	endtask

	// Mostly on-screen coordinates, now and then anything the fields can hold.
	task automatic queue_pixel(kind_t k);
		int x;
		int y;
		x = ($urandom_range(0, 99) < 85) ? $urandom_range(0, COLS - 1) : $urandom_range(0, 255);
		y = ($urandom_range(0, 99) < 85) ? $urandom_range(0, ROWS - 1) : $urandom_range(0, 255);
		queue_cmd(k, x, y, $urandom_range(0, 3));
	endtask

	task automatic queue_control(kind_t k);
		queue_cmd(k, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 3));
	endtask

	// Sender: a command is presented until its transfer and then replaced from the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in.valid     <= 1'b0;
			pix_in.kind      <= KIND_WRITE;
			pix_in.pos_x     <= '0;
			pix_in.pos_y     <= '0;
			pix_in.dot_color <= PIX_OFF;
		end else begin
			if (pix_in.valid && pix_in.ready) begin
				apply_command(kind_t'(pix_in.kind), pix_in.pos_x, pix_in.pos_y,
					dot_color_t'(pix_in.dot_color));
				cmds_taken++;
			end
			if (!pix_in.valid || pix_in.ready) begin
				if (cmd_queue.size() == 0 || (!calm && $urandom_range(0, 99) < 7) ||
						(cmd_queue[0].drain && rows_due.size() != 0)) begin
					pix_in.valid <= 1'b0;
				end else begin
					next_cmd = cmd_queue.pop_front();
					pix_in.valid     <= 1'b1;
					pix_in.kind      <= next_cmd.kind;
					pix_in.pos_x     <= next_cmd.x;
					pix_in.pos_y     <= next_cmd.y;
					pix_in.dot_color <= next_cmd.color;
				end
			end
		end
	end

	// Receiver: every row transfer is checked against the oldest predicted row.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_out.ready <= 1'b0;
		end else begin
			if (row_out.valid && row_out.ready) begin
				if (rows_due.size() == 0) begin
					$error("row_addr: no row expected, got %0d", row_out.row_addr);
					errors++;
				end else begin
					got_row = rows_due.pop_front();
					if (row_out.row_addr !== got_row.addr) begin
						$error("row_addr: expected %0d, got %0d", got_row.addr, row_out.row_addr);
						errors++;
					end
					if (row_out.red_row !== got_row.red) begin
						$error("red_row: expected %h, got %h", got_row.red, row_out.red_row);
						errors++;
					end
					if (row_out.green_row !== got_row.green) begin
						$error("green_row: expected %h, got %h", got_row.green, row_out.green_row);
						errors++;
					end
					if (row_out.last_row !== got_row.last) begin
						$error("last_row: expected %b, got %b", got_row.last, row_out.last_row);
						errors++;
					end
				end
			end
			row_out.ready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_color_led_framebuffer_scan_unit_tb failed");
			$finish;
		end
	end

	initial begin
		int depth;
		int issued;
		int n;
		int r;
		bit nested;

		arst_n = 1'b0;
		depth  = 0;
		issued = 0;

		// Directed: corners, panel seam, every colour, every way off screen, nesting.
		queue_cmd(KIND_DRAW, 0, 0, PIX_RED);
		queue_cmd(KIND_START, -1, -1, PIX_BOTH);
		queue_cmd(KIND_WRITE, 63, 15, PIX_BOTH);
		queue_cmd(KIND_WRITE, 0, 15, PIX_GREEN);
		queue_cmd(KIND_WRITE, 63, 0, PIX_RED);
		queue_cmd(KIND_WRITE, 31, 8, PIX_BOTH);
		queue_cmd(KIND_WRITE, 32, 7, PIX_GREEN);
		queue_cmd(KIND_WRITE, 64, 3, PIX_RED);
		queue_cmd(KIND_WRITE, -1, 3, PIX_RED);
		queue_cmd(KIND_WRITE, -128, -128, PIX_BOTH);
		queue_cmd(KIND_WRITE, 127, 127, PIX_BOTH);
		queue_cmd(KIND_WRITE, 5, 16, PIX_GREEN);
		queue_cmd(KIND_WRITE, 5, -1, PIX_GREEN);
		queue_cmd(KIND_START, 127, 0, PIX_OFF);
		queue_cmd(KIND_DRAW, 10, 10, PIX_BOTH);
		queue_cmd(KIND_WRITE, 63, 0, PIX_OFF);
		queue_cmd(KIND_END, -128, 127, PIX_RED);
		queue_cmd(KIND_END, 0, 0, PIX_OFF);
		queue_cmd(KIND_END, 85, -86, PIX_GREEN);
		queue_cmd(KIND_DRAW, -1, 4, PIX_RED);
		queue_cmd(KIND_WRITE, 0, 0, PIX_OFF);
		queue_cmd(KIND_DRAW, 63, 15, PIX_OFF);

		// Random: mostly complete transactions, some lone draws, some broken sequences.
		queue_cmd(KIND_WRITE, 1, 1, PIX_GREEN, 1'b1);
		while (issued < 225) begin
			if (depth > 0 && $urandom_range(0, 1) == 1) begin
				queue_control(KIND_END);
				depth--;
				issued++;
			end
			r = $urandom_range(0, 99);
			if (r < 55) begin
				nested = ($urandom_range(0, 3) == 0);
				n      = $urandom_range(1, 12);
				queue_control(KIND_START);
				if (nested)
					queue_control(KIND_START);
				for (int i = 0; i < n; i++)
					queue_pixel(($urandom_range(0, 4) == 0) ? KIND_DRAW : KIND_WRITE);
				if (nested)
					queue_control(KIND_END);
				if ($urandom_range(0, 9) == 0)
					depth++;
				else
					queue_control(KIND_END);
				issued += n + (nested ? 4 : 2);
			end else if (r < 75) begin
				queue_pixel(KIND_DRAW);
				issued++;
			end else if (r < 85) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					queue_pixel(KIND_WRITE);
				issued += n;
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					queue_cmd(kind_t'(2'($urandom_range(0, 3))), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 3));
					if (cmd_queue[$].kind == KIND_START)
						depth++;
					else if (cmd_queue[$].kind == KIND_END && depth > 0)
						depth--;
				end
				issued += n;
			end
		end
		while (depth > 0) begin
			queue_control(KIND_END);
			depth--;
		end
		queue_cmd(KIND_DRAW, 20, 5, PIX_BOTH);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || pix_in.valid || rows_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && rows_due.size() == 0)
			$display("two_color_led_framebuffer_scan_unit_tb passed");
		else
			$display("two_color_led_framebuffer_scan_unit_tb failed");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/tcfb_pkg.sv
rtl/core/tcfb_in_if.sv
rtl/core/tcfb_out_if.sv
rtl/core/two_color_led_framebuffer_scan_unit.sv
bench/two_color_led_framebuffer_scan_unit_tb.sv
